// ===== rtl/ccesl_pkg.sv =====
package ccesl_pkg;

    // source classes and set table size
    localparam int NUM_CLASSES = 32;
    localparam int MAX_SETS    = 256;

    // field widths
    localparam int CP_W        = 21;
    localparam int MASK_W      = 32;
    localparam int SET_INDEX_W = 8;

    // table index and fill count widths
    localparam int IDX_W = $clog2(MAX_SETS);
    localparam int CNT_W = $clog2(MAX_SETS + 1);

    // highest valid codepoint
    localparam logic [CP_W-1:0] CP_MAX = CP_W'(32'h10FFFF);

    // classes that take part in the membership set
    localparam logic [MASK_W-1:0] CLASS_MASK = (NUM_CLASSES >= MASK_W) ?
        {MASK_W{1'b1}} : MASK_W'((64'd1 << NUM_CLASSES) - 64'd1);

    // result kinds
    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_SET   = 1'b1;

    // lookup request to the set table
    typedef struct packed {
        logic              lookup;
        logic              clear;
        logic [MASK_W-1:0] key;
    } tbl_req_t;

    // lookup answer from the set table, valid for one cycle
    typedef struct packed {
        logic             done;
        logic             found;
        logic             overflow;
        logic [IDX_W-1:0] idx;
    } tbl_resp_t;

endpackage

// ===== rtl/ccesl_set_table.sv =====
module ccesl_set_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccesl_pkg::tbl_req_t  req,
    output ccesl_pkg::tbl_resp_t resp
);
    import ccesl_pkg::*;

    typedef enum logic {
        T_IDLE,
        T_SCAN
    } tstate_t;

    tstate_t           tstate_reg, tstate_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic [MASK_W-1:0] key_reg, key_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    tbl_resp_t         resp_reg, resp_next;

    // set storage, entry 0 is the empty set and is never stored
    logic [MASK_W-1:0] mem [MAX_SETS];
    logic [MASK_W-1:0] mem_q;
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;

    // memory port, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= key_reg;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    // scan sequencer: one read issued per cycle, each compared in the cycle after its read
    always_comb
    begin
        logic [CNT_W-1:0] cnt_eff;
        cnt_eff      = cnt_reg;
        tstate_next  = tstate_reg;
        cnt_next     = cnt_reg;
        addr_next    = addr_reg;
        key_next     = key_reg;
        rd_pend_next = 1'b0;
        rd_idx_next  = rd_idx_reg;
        resp_next    = '0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = addr_reg[IDX_W-1:0];
        wr_addr      = cnt_reg[IDX_W-1:0];
        unique case (tstate_reg)
            T_IDLE:
            begin
                cnt_eff  = req.clear ? CNT_W'(1) : cnt_reg;
                cnt_next = cnt_eff;
                if (req.lookup)
                begin
                    key_next = req.key;
                    if (req.key == '0)
                    begin
                        // empty set always sits at index 0
                        resp_next.done  = 1'b1;
                        resp_next.found = 1'b1;
                        resp_next.idx   = '0;
                    end
                    else
                    begin
                        addr_next   = CNT_W'(1);
                        tstate_next = T_SCAN;
                    end
                end
            end
            T_SCAN:
            begin
                if (rd_pend_reg && (mem_q == key_reg))
                begin
                    resp_next.done  = 1'b1;
                    resp_next.found = 1'b1;
                    resp_next.idx   = rd_idx_reg;
                    tstate_next     = T_IDLE;
                end
                else if (addr_reg < cnt_reg)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = addr_reg[IDX_W-1:0];
                    addr_next    = addr_reg + CNT_W'(1);
                end
                else if (!rd_pend_reg)
                begin
                    // miss: store the set if there is room
                    resp_next.done = 1'b1;
                    if (cnt_reg < CNT_W'(MAX_SETS))
                    begin
                        wr_en         = 1'b1;
                        resp_next.idx = cnt_reg[IDX_W-1:0];
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        resp_next.overflow = 1'b1;
                        resp_next.idx      = '0;
                    end
                    tstate_next = T_IDLE;
                end
            end
            default:
            begin
                tstate_next = T_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tstate_reg  <= T_IDLE;
            cnt_reg     <= CNT_W'(1);
            addr_reg    <= '0;
            key_reg     <= '0;
            rd_pend_reg <= 1'b0;
            rd_idx_reg  <= '0;
            resp_reg    <= '0;
        end
        else
        begin
            tstate_reg  <= tstate_next;
            cnt_reg     <= cnt_next;
            addr_reg    <= addr_next;
            key_reg     <= key_next;
            rd_pend_reg <= rd_pend_next;
            rd_idx_reg  <= rd_idx_next;
            resp_reg    <= resp_next;
        end
    end

    assign resp = resp_reg;

endmodule

// ===== rtl/char_class_exclusive_set_labeler_core.sv =====
// throughput: one breakpoint at a time; the set table scan reads one stored set per cycle
// from its single memory read port, so the scan length sets the rate
// reset: membership set, open range and index cleared, the table holds only the empty set
// no clearing pass: table entries above the fill count are never read
module char_class_exclusive_set_labeler_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   bp_valid,
    output logic                                   bp_stall,
    input  logic                                   restart,
    input  logic [ccesl_pkg::CP_W-1:0]             codepoint,
    input  logic [ccesl_pkg::MASK_W-1:0]           toggle_mask,
    output logic                                   res_valid,
    input  logic                                   res_stall,
    output logic                                   kind,
    output logic [ccesl_pkg::CP_W-1:0]             span_first,
    output logic [ccesl_pkg::CP_W-1:0]             span_last,
    output logic [ccesl_pkg::SET_INDEX_W-1:0]      set_index,
    output logic [ccesl_pkg::MASK_W-1:0]           set_mask,
    output logic                                   overflow,
    output logic                                   last
);
    import ccesl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT
    } state_t;

    state_t            state_reg;
    logic [MASK_W-1:0] member_reg;
    logic [CP_W-1:0]   start_reg;
    logic [IDX_W-1:0]  open_idx_reg;

    // pending results of the current transaction
    logic              rng_pend_reg;
    logic [CP_W-1:0]   rng_lo_reg;
    logic [CP_W-1:0]   rng_hi_reg;
    logic [IDX_W-1:0]  rng_idx_reg;
    logic              set_pend_reg;
    logic [IDX_W-1:0]  set_idx_reg;
    logic              set_ovf_reg;

    // output register
    logic              res_valid_reg;
    logic              kind_reg;
    logic [CP_W-1:0]   span_first_reg;
    logic [CP_W-1:0]   span_last_reg;
    logic [SET_INDEX_W-1:0] set_index_reg;
    logic [MASK_W-1:0] set_mask_reg;
    logic              overflow_reg;
    logic              last_reg;

    tbl_req_t          req;
    tbl_resp_t         resp;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [MASK_W-1:0] member_eff;
    logic [CP_W-1:0]   start_eff;
    logic [IDX_W-1:0]  open_idx_eff;
    logic [MASK_W-1:0] member_new;
    logic [CP_W-1:0]   hi_raw;
    logic [CP_W-1:0]   hi_sat;
    logic              beyond_max;

    assign accept   = bp_valid && !bp_stall;
    assign bp_stall = (state_reg != S_IDLE);
    assign out_free = !res_valid_reg || !res_stall;
    assign out_load = (state_reg == S_EMIT) && (rng_pend_reg || set_pend_reg) && out_free;

    // state as seen after an optional restart
    assign member_eff   = restart ? '0 : member_reg;
    assign start_eff    = restart ? '0 : start_reg;
    assign open_idx_eff = restart ? '0 : open_idx_reg;
    assign member_new   = member_eff ^ (toggle_mask & CLASS_MASK);
    assign beyond_max   = codepoint > CP_MAX;

    // closing codepoint of the open range, clamped to the last valid codepoint
    assign hi_raw = codepoint - CP_W'(1);
    assign hi_sat = (hi_raw > CP_MAX) ? CP_MAX : hi_raw;

    // table request, issued with the transaction
    assign req.lookup = accept && !beyond_max;
    assign req.clear  = accept && restart;
    assign req.key    = member_new;

    ccesl_set_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .resp  (resp)
    );

    // control sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            member_reg     <= '0;
            start_reg      <= '0;
            open_idx_reg   <= '0;
            rng_pend_reg   <= 1'b0;
            rng_lo_reg     <= '0;
            rng_hi_reg     <= '0;
            rng_idx_reg    <= '0;
            set_pend_reg   <= 1'b0;
            set_idx_reg    <= '0;
            set_ovf_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
            kind_reg       <= KIND_RANGE;
            span_first_reg <= '0;
            span_last_reg  <= '0;
            set_index_reg  <= '0;
            set_mask_reg   <= '0;
            overflow_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            // output valid: load a pending result or retire the accepted one
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rng_pend_reg <= (open_idx_eff != '0) && (codepoint > start_eff);
                        rng_lo_reg   <= start_eff;
                        rng_hi_reg   <= hi_sat;
                        rng_idx_reg  <= open_idx_eff;
                        set_pend_reg <= 1'b0;
                        if (beyond_max)
                        begin
                            member_reg   <= member_eff;
                            start_reg    <= start_eff;
                            open_idx_reg <= '0;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            member_reg <= member_new;
                            start_reg  <= codepoint;
                            state_reg  <= S_LOOK;
                        end
                    end
                end
                S_LOOK:
                begin
                    if (resp.done)
                    begin
                        open_idx_reg <= resp.found ? resp.idx :
                                        (resp.overflow ? '0 : resp.idx);
                        set_pend_reg <= !resp.found;
                        set_idx_reg  <= resp.idx;
                        set_ovf_reg  <= resp.overflow;
                        state_reg    <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (rng_pend_reg)
                    begin
                        if (out_free)
                        begin
                            kind_reg       <= KIND_RANGE;
                            span_first_reg <= rng_lo_reg;
                            span_last_reg  <= rng_hi_reg;
                            set_index_reg  <= SET_INDEX_W'(rng_idx_reg);
                            set_mask_reg   <= '0;
                            overflow_reg   <= 1'b0;
                            last_reg       <= !set_pend_reg;
                            rng_pend_reg   <= 1'b0;
                            if (!set_pend_reg)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    else if (set_pend_reg)
                    begin
                        if (out_free)
                        begin
                            kind_reg       <= KIND_SET;
                            span_first_reg <= '0;
                            span_last_reg  <= '0;
                            set_index_reg  <= SET_INDEX_W'(set_idx_reg);
                            set_mask_reg   <= member_reg;
                            overflow_reg   <= set_ovf_reg;
                            last_reg       <= 1'b1;
                            set_pend_reg   <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                    else
                    begin
                        // transaction with no result
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign kind       = kind_reg;
    assign span_first = span_first_reg;
    assign span_last  = span_last_reg;
    assign set_index  = set_index_reg;
    assign set_mask   = set_mask_reg;
    assign overflow   = overflow_reg;
    assign last       = last_reg;

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccesl_pkg::*;

    localparam int ITEM_TARGET    = 400;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [CP_W-1:0] CP_END = CP_W'(32'h110000);

    // one breakpoint as queued for the driver
    typedef struct {
        logic              restart;
        logic [CP_W-1:0]   codepoint;
        logic [MASK_W-1:0] toggle_mask;
        logic              drain;
    } bp_item_t;

    // one result transaction
    typedef struct {
        logic                   kind;
        logic [CP_W-1:0]        span_first;
        logic [CP_W-1:0]        span_last;
        logic [SET_INDEX_W-1:0] set_index;
        logic [MASK_W-1:0]      set_mask;
        logic                   overflow;
        logic                   last;
    } report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   bp_valid = 1'b0;
    logic                   bp_stall;
    logic                   restart = 1'b0;
    logic [CP_W-1:0]        codepoint = '0;
    logic [MASK_W-1:0]      toggle_mask = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    logic                   kind;
    logic [CP_W-1:0]        span_first;
    logic [CP_W-1:0]        span_last;
    logic [SET_INDEX_W-1:0] set_index;
    logic [MASK_W-1:0]      set_mask;
    logic                   overflow;
    logic                   last;

    bp_item_t pending_bps[$];
    report_t  expected_reports[$];
    bp_item_t next_bp;

    // partition state kept alongside the block
    logic [MASK_W-1:0]      cur_members;
    logic [CP_W-1:0]        range_start;
    logic [SET_INDEX_W-1:0] range_index;
    logic [MASK_W-1:0]      known_sets[MAX_SETS];
    int                     next_set;

    int  send_idle_pct = 22;
    int  recv_idle_pct = 74;
    logic bp_fired = 1'b0;
    int  bps_accepted = 0;
    int  total_bps = 0;
    int  directed_count = 0;
    int  errors = 0;
    int  stuck_cycles = 0;
    int  ranges_seen = 0;
    int  sets_seen = 0;
    int  overflows_seen = 0;
    int  restarts_seen = 0;
    bit  overflow_done = 0;

    char_class_exclusive_set_labeler_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .bp_valid   (bp_valid),
        .bp_stall   (bp_stall),
        .restart    (restart),
        .codepoint  (codepoint),
        .toggle_mask(toggle_mask),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .kind       (kind),
        .span_first (span_first),
        .span_last  (span_last),
        .set_index  (set_index),
        .set_mask   (set_mask),
        .overflow   (overflow),
        .last       (last)
    );

    // clock
    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // closes the open range and labels the new membership set
    function automatic void label_breakpoint(input logic rs, input logic [CP_W-1:0] cp,
                                             input logic [MASK_W-1:0] tm);
        report_t          outs[2];
        int               n;
        int               found_at;
        logic [CP_W-1:0]  hi;
        logic [MASK_W-1:0] toggles;
        n = 0;
        found_at = -1;
        toggles = tm & CLASS_MASK;
        if (rs)
        begin
            cur_members = '0;
            range_start = '0;
            range_index = '0;
            known_sets[0] = '0;
            next_set = 1;
        end
        // range ending just below this breakpoint
        if (range_index != 0 && cp > range_start)
        begin
            hi = cp - 1'b1;
            if (hi > CP_MAX)
                hi = CP_MAX;
            outs[n].kind = KIND_RANGE;
            outs[n].span_first = range_start;
            outs[n].span_last = hi;
            outs[n].set_index = range_index;
            outs[n].set_mask = '0;
            outs[n].overflow = 1'b0;
            outs[n].last = 1'b0;
            n++;
        end
        if (cp > CP_MAX)
        begin
            range_index = '0;
        end
        else
        begin
            range_start = cp;
            cur_members ^= toggles;
            for (int i = 0; i < next_set && i < MAX_SETS; i++)
            begin
                if (found_at < 0 && known_sets[i] == cur_members)
                    found_at = i;
            end
            if (found_at >= 0)
            begin
                range_index = SET_INDEX_W'(found_at);
            end
            else
            begin
                outs[n].kind = KIND_SET;
                outs[n].span_first = '0;
                outs[n].span_last = '0;
                outs[n].set_mask = cur_members;
                outs[n].last = 1'b0;
                if (next_set < MAX_SETS)
                begin
                    known_sets[next_set] = cur_members;
                    range_index = SET_INDEX_W'(next_set);
                    outs[n].set_index = SET_INDEX_W'(next_set);
                    outs[n].overflow = 1'b0;
                    next_set++;
                end
                else
                begin
                    // table full: reported but never stored
                    range_index = '0;
                    outs[n].set_index = '0;
                    outs[n].overflow = 1'b1;
                end
                n++;
            end
        end
        if (n > 0)
            outs[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_reports.insert(expected_reports.size(), outs[k]);
    endfunction

    // compare one result transaction with the oldest expectation
    task automatic check_report();
        report_t want;
        if (expected_reports.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("unexpected result: kind %0d lo %h hi %h idx %0d mask %h ovf %0d last %0d",
                         kind, span_first, span_last, set_index, set_mask, overflow, last);
        end
        else
        begin
            want = expected_reports.pop_front();
            if (kind !== want.kind || span_first !== want.span_first
                || span_last !== want.span_last || set_index !== want.set_index
                || set_mask !== want.set_mask || overflow !== want.overflow
                || last !== want.last)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("mismatch at %0t:", $realtime);
                    $display("  expected kind %0d lo %h hi %h idx %0d mask %h ovf %0d last %0d",
                             want.kind, want.span_first, want.span_last,
                             want.set_index, want.set_mask, want.overflow, want.last);
                    $display("  actual   kind %0d lo %h hi %h idx %0d mask %h ovf %0d last %0d",
                             kind, span_first, span_last, set_index, set_mask, overflow, last);
                end
            end
            if (kind == KIND_RANGE)
                ranges_seen++;
            else if (overflow)
                overflows_seen++;
            else
                sets_seen++;
        end
    endtask

    // driver: next breakpoint and receiver stall at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!bp_valid || bp_fired))
        begin
            if (pending_bps.size() > 0
                && !(pending_bps[0].drain && expected_reports.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_bp = pending_bps.pop_front();
                bp_valid <= 1'b1;
                restart <= next_bp.restart;
                codepoint <= next_bp.codepoint;
                toggle_mask <= next_bp.toggle_mask;
            end
            else
            begin
                bp_valid <= 1'b0;
            end
        end
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor: accepted transactions at the rising edge
    always @(posedge clk)
    begin
        bp_fired = rst_n && bp_valid && !bp_stall;
        if (bp_fired)
        begin
            label_breakpoint(restart, codepoint, toggle_mask);
            bps_accepted++;
            if (restart)
                restarts_seen++;
        end
        if (rst_n && res_valid && !res_stall)
            check_report();
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (bp_valid && !bp_stall) || (res_valid && !res_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stuck_cycles, expected_reports.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_bp(input logic rs, input logic [CP_W-1:0] cp,
                          input logic [MASK_W-1:0] tm, input logic hold);
        bp_item_t b;
        b.restart = rs;
        b.codepoint = cp;
        b.toggle_mask = tm;
        b.drain = hold;
        pending_bps.insert(pending_bps.size(), b);
    endtask

    // a few toggles among a handful of classes, so sets recur
    function automatic logic [MASK_W-1:0] sparse_toggles();
        logic [MASK_W-1:0] m;
        m = '0;
        m[$urandom_range(0, 4)] = 1'b1;
        if ($urandom_range(0, 2) == 0)
            m[$urandom_range(0, 4)] ^= 1'b1;
        if ($urandom_range(0, 9) == 0)
            m[$urandom_range(0, 31)] ^= 1'b1;
        return m;
    endfunction

    // one alphabet: restart, ascending breakpoints, usually a closing breakpoint
    task automatic add_alphabet(input int len, input bit dense);
        int cp;
        int roll;
        logic rs;
        logic [MASK_W-1:0] tm;
        cp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 'h3000);
        for (int k = 0; k < len; k++)
        begin
            rs = (k == 0);
            tm = dense ? $urandom : sparse_toggles();
            roll = dense ? 100 : $urandom_range(0, 99);
            if (roll < 5)
            begin
                // possibly out of order, anywhere from 0 up to the next ascending codepoint
                add_bp(rs, CP_W'($urandom_range(0, cp)), tm, 1'b0);
            end
            else if (roll < 9)
            begin
                add_bp(rs, CP_W'($urandom_range(0, 32'h1FFFFF)), tm, 1'b0);
            end
            else if (roll < 12)
            begin
                add_bp(1'b1, CP_W'(cp), tm, 1'b0);
            end
            else
            begin
                if (roll < 15)
                    tm = $urandom;
                add_bp(rs, CP_W'(cp), tm, (k == 0) && (dense || $urandom_range(0, 9) == 0));
                if (dense)
                    cp += $urandom_range(1, 4000);
                else
                    cp += $urandom_range(1, $urandom_range(0, 1) ? 64 : 'h8000);
                if (cp > CP_MAX)
                    break;
            end
        end
        if (!dense && $urandom_range(0, 99) < 85)
            add_bp(1'b0, CP_END, $urandom, 1'b0);
    endtask

    // stimulus, reset and run phases
    initial
    begin
        // directed: ordering, extremes, saturation, restart
        add_bp(1'b1, '0, '0, 1'b0);
        add_bp(1'b0, CP_W'('h41), 32'h1, 1'b0);
        add_bp(1'b0, CP_W'('h41), 32'h2, 1'b0);
        add_bp(1'b0, CP_W'('h5B), 32'h3, 1'b0);
        add_bp(1'b0, CP_W'('h61), 32'h1, 1'b0);
        add_bp(1'b0, CP_W'('h7B), 32'hFFFF_FFFF, 1'b0);
        add_bp(1'b0, CP_MAX, 32'h8000_0000, 1'b0);
        add_bp(1'b0, CP_END, 32'h1234_5678, 1'b0);
        add_bp(1'b0, CP_END, 32'h1, 1'b0);
        add_bp(1'b0, CP_W'('h100), 32'h4, 1'b0);
        add_bp(1'b0, CP_W'(32'h1F_FFFF), 32'h0000_FFFF, 1'b0);
        add_bp(1'b0, CP_W'(32'h10_0000), 32'h0, 1'b0);
        add_bp(1'b1, CP_W'(32'h0A_AAAA), 32'hAAAA_AAAA, 1'b0);
        add_bp(1'b0, CP_W'(32'h15_5555), 32'h5555_5555, 1'b0);
        add_bp(1'b1, '0, '0, 1'b0);
        add_bp(1'b0, CP_W'('h30), 32'h1, 1'b0);
        add_bp(1'b0, CP_W'('h3A), 32'h1, 1'b1);
        directed_count = pending_bps.size();

        // random alphabets, one of them long enough to fill the table
        while (pending_bps.size() < directed_count + ITEM_TARGET)
        begin
            if (!overflow_done && pending_bps.size() >= directed_count + 60)
            begin
                add_alphabet(264, 1'b1);
                overflow_done = 1;
            end
            else
            begin
                add_alphabet($urandom_range(3, 12), 1'b0);
            end
        end
        total_bps = pending_bps.size();

        // reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idle mix: sender light, receiver heavy, then swapped, then none
        while (bps_accepted < total_bps / 3)
            @(posedge clk);
        send_idle_pct = 74;
        recv_idle_pct = 22;
        while (bps_accepted < (2 * total_bps) / 3)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // drain
        while (bps_accepted < total_bps || expected_reports.size() != 0)
            @(posedge clk);
        repeat (MAX_SETS + 16) @(posedge clk);

        $display("run covered %0d breakpoints (%0d with restart) and %0d range reports",
                 bps_accepted, restarts_seen, ranges_seen);
        $display("plus %0d new sets and %0d table-full reports, %0d errors",
                 sets_seen, overflows_seen, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== char_class_exclusive_set_labeler_core.f =====
rtl/ccesl_pkg.sv
rtl/ccesl_set_table.sv
rtl/char_class_exclusive_set_labeler_core.sv
sim/testbench.sv
